// ===== src/kpc_pkg.sv =====
// Shared types and constants of the knob position conditioner.
package kpc_pkg;

    // Field widths.
    localparam int ADC_W     = 12;
    localparam int POS_W     = 16;
    localparam int ALPHA_W   = 16;
    localparam int DZ_W      = 15;
    localparam int MODE_W    = 2;
    localparam int FRAC_W    = 16;
    localparam int SMOOTH_W  = ADC_W + FRAC_W;
    localparam int QPOS_W    = 14;
    localparam int QCLAMP_W  = QPOS_W + 1;

    // Shared divider geometry: a position dividend is a millivolt difference shifted by 14.
    localparam int DIV_W     = ADC_W + QPOS_W;
    localparam int DVS_W     = ADC_W;
    localparam int DIV_CNT_W = 5;

    // Full scale of the position, 1.0 in Q2.14.
    localparam logic [QCLAMP_W-1:0] POS_ONE = 15'd16384;

    // Register indexes on the configuration port.
    localparam int IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_LEFT     = 3'd0;
    localparam logic [IDX_W-1:0] IDX_CENTER   = 3'd1;
    localparam logic [IDX_W-1:0] IDX_RIGHT    = 3'd2;
    localparam logic [IDX_W-1:0] IDX_ALPHA    = 3'd3;
    localparam logic [IDX_W-1:0] IDX_DEADZONE = 3'd4;

    // Register reset values.
    localparam logic [ADC_W-1:0]   RST_LEFT     = 12'd3145;
    localparam logic [ADC_W-1:0]   RST_CENTER   = 12'd2100;
    localparam logic [ADC_W-1:0]   RST_RIGHT    = 12'd142;
    localparam logic [ALPHA_W-1:0] RST_ALPHA    = 16'd13107;
    localparam logic [DZ_W-1:0]    RST_DEADZONE = 15'd492;

    // Filter mode codes.
    localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HIGH   = 2'd2;

    // Configuration register set.
    typedef struct packed {
        logic [ADC_W-1:0]   left_mv;
        logic [ADC_W-1:0]   center_mv;
        logic [ADC_W-1:0]   right_mv;
        logic [ALPHA_W-1:0] ema_alpha;
        logic [DZ_W-1:0]    deadzone;
    } t_cfg;

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== src/kpc_front.sv =====
// Front end: accepts readings and sums them into bursts.
module kpc_front #(
    parameter int LIMIT = 16,
    parameter int SUM_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_tvalid,
    output logic                     o_tready,
    input  logic [kpc_pkg::ADC_W-1:0] i_adc_mv,
    input  logic                     i_full,
    output logic                     o_push,
    output logic [SUM_W-1:0]         o_sum
);

    localparam int CNT_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(LIMIT - 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             w_accept;
    logic [SUM_W-1:0] w_total;

    // A reading is taken whenever the queue can still hold a finished burst.
    assign o_tready = !i_full;
    assign w_accept = i_tvalid && o_tready;
    assign w_total  = r_sum + SUM_W'(i_adc_mv);

    // The last reading of a burst pushes the total and restarts the sum.
    assign o_push = w_accept && (r_count == LAST);
    assign o_sum  = w_total;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (w_accept) begin
            if (r_count == LAST) begin
                n_count = '0;
                n_sum   = '0;
            end else begin
                n_count = r_count + 1'b1;
                n_sum   = w_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== src/kpc_fifo.sv =====
// Two-entry queue that carries burst totals from the front end to the back end.
module kpc_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_level;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 2'd1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 2'd1;
            end
        end
    end

endmodule

// ===== src/kpc_div.sv =====
// Restoring divider that resolves one quotient bit per cycle.
module kpc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [kpc_pkg::DIV_W-1:0] i_dividend,
    input  logic [kpc_pkg::DVS_W-1:0] i_divisor,
    output kpc_pkg::t_div_status      o_status,
    output logic [kpc_pkg::DIV_W-1:0] o_quotient
);

    localparam int DW = kpc_pkg::DIV_W;
    localparam int VW = kpc_pkg::DVS_W;

    logic [DW-1:0]                  r_dvd;
    logic [VW-1:0]                  r_rem;
    logic [VW-1:0]                  r_div;
    logic [kpc_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [VW:0]                    w_shift;
    logic                           w_ge;
    logic [VW:0]                    w_diff;

    // One step: shift in the next dividend bit and subtract when it fits.
    assign w_shift = {r_rem, r_dvd[DW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_dvd;

    // Payload: dividend shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[VW-1:0] : w_shift[VW-1:0];
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kpc_pkg::DIV_CNT_W'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== src/kpc_back.sv =====
// Back end: burst mean, exponential average, position mapping and result register.
module kpc_back #(
    parameter int LIMIT = 16,
    parameter int SUM_W = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kpc_pkg::t_cfg                i_cfg,
    input  logic                         i_empty,
    input  logic [SUM_W-1:0]             i_sum,
    output logic                         o_pop,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [kpc_pkg::POS_W-1:0]    o_knob_position,
    output logic [kpc_pkg::ADC_W-1:0]    o_smoothed_mv,
    output logic [kpc_pkg::MODE_W-1:0]   o_filter_mode
);

    localparam int ADC_W = kpc_pkg::ADC_W;
    localparam int SW    = kpc_pkg::SMOOTH_W;
    localparam int FW    = kpc_pkg::FRAC_W;
    localparam int QW    = kpc_pkg::QCLAMP_W;
    localparam int PW    = kpc_pkg::POS_W;
    localparam int P2_W  = kpc_pkg::ALPHA_W + 1 + SW;

    // Burst mean by reciprocal multiplication: exact for every sum below 2**SUM_W.
    localparam int REC_L  = (LIMIT > 1) ? $clog2(LIMIT) : 0;
    localparam int REC_S  = SUM_W + REC_L;
    localparam int REC_MW = SUM_W + 1;
    localparam logic [REC_MW-1:0] REC_M =
        REC_MW'(((64'd1 << REC_S) + 64'(LIMIT) - 64'd1) / 64'(LIMIT));

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MEAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_MAP  = 3'd4;
    localparam logic [2:0] S_POS  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                   r_state;
    logic                         r_primed;
    logic [SW-1:0]                r_smooth;
    logic [SUM_W-1:0]             r_sum;
    logic [ADC_W-1:0]             r_mean;
    logic [SW-1:0]                r_p1;
    logic [P2_W-1:0]              r_p2;
    logic [QW-1:0]                r_q;
    logic                         r_neg;
    logic                         r_out_valid;
    logic [PW-1:0]                r_pos;
    logic [ADC_W-1:0]             r_mv_out;
    logic [kpc_pkg::MODE_W-1:0]   r_mode;

    logic                         w_div_start;
    logic [kpc_pkg::DIV_W-1:0]    w_div_dvd;
    logic [kpc_pkg::DVS_W-1:0]    w_div_dvs;
    kpc_pkg::t_div_status         w_div_st;
    logic [kpc_pkg::DIV_W-1:0]    w_quot;

    logic [SUM_W+REC_MW-1:0]      w_mean_prod;
    logic [ADC_W-1:0]             w_mv;
    logic                         w_upper;
    logic [ADC_W-1:0]             w_num;
    logic signed [ADC_W:0]        w_den;
    logic [ADC_W-1:0]             w_mag;
    logic                         w_neg;
    logic [kpc_pkg::ALPHA_W:0]    w_inv_alpha;
    logic [SW:0]                  w_ema_sum;
    logic                         w_load;
    logic [QW-1:0]                w_qz;
    logic [PW-1:0]                w_qext;

    kpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_status   (w_div_st),
        .o_quotient (w_quot)
    );

    // Burst total times the scaled reciprocal of the burst length.
    assign w_mean_prod = r_sum * REC_M;

    // Half selection around the center and the signed span of that half.
    assign w_mv    = r_smooth[SW-1:FW];
    assign w_upper = (w_mv >= i_cfg.center_mv);
    always_comb begin
        if (w_upper) begin
            w_num = w_mv - i_cfg.center_mv;
            w_den = $signed({1'b0, i_cfg.left_mv}) - $signed({1'b0, i_cfg.center_mv});
        end else begin
            w_num = i_cfg.center_mv - w_mv;
            w_den = $signed({1'b0, i_cfg.center_mv}) - $signed({1'b0, i_cfg.right_mv});
        end
    end
    assign w_mag = w_den[ADC_W] ? ADC_W'(-w_den) : w_den[ADC_W-1:0];
    assign w_neg = w_upper ^ w_den[ADC_W];

    // The divider works out the position quotient when the span is not zero.
    assign w_div_start = (r_state == S_MAP) && (w_den != '0);
    assign w_div_dvd   = {w_num, {kpc_pkg::QPOS_W{1'b0}}};
    assign w_div_dvs   = w_mag;
    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // Average update: alpha*mean plus the integer part of (1-alpha)*old.
    assign w_inv_alpha = {1'b1, {kpc_pkg::ALPHA_W{1'b0}}} - {1'b0, i_cfg.ema_alpha};
    assign w_ema_sum   = {1'b0, r_p1} + r_p2[P2_W-1:FW];

    // Deadzone, sign and mode of the finished position.
    assign w_qz   = (r_q < i_cfg.deadzone) ? '0 : r_q;
    assign w_qext = PW'(w_qz);
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_tready);

    // Sequencer for one burst.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_primed <= 1'b0;
            r_smooth <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (!r_primed) begin
                        r_smooth <= {r_mean, {FW{1'b0}}};
                        r_primed <= 1'b1;
                        r_state  <= S_MAP;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_smooth <= w_ema_sum[SW-1:0];
                    r_state  <= S_MAP;
                end
                S_MAP: begin
                    r_state <= (w_den == '0) ? S_OUT : S_POS;
                end
                S_POS: begin
                    if (w_div_st.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_sum <= i_sum;
        end
        if (r_state == S_MEAN) begin
            r_mean <= w_mean_prod[REC_S +: ADC_W];
        end
        if (r_state == S_MUL) begin
            r_p1 <= SW'(i_cfg.ema_alpha * r_mean);
            r_p2 <= w_inv_alpha * r_smooth;
        end
        if (r_state == S_MAP) begin
            r_neg <= w_neg;
            r_q   <= '0;
        end
        if ((r_state == S_POS) && w_div_st.done) begin
            r_q <= (w_quot > kpc_pkg::DIV_W'(kpc_pkg::POS_ONE)) ? kpc_pkg::POS_ONE
                                                                : w_quot[QW-1:0];
        end
        if (w_load) begin
            r_pos    <= r_neg ? (PW'(0) - w_qext) : w_qext;
            r_mv_out <= w_mv;
            if (w_qz == '0) begin
                r_mode <= kpc_pkg::MODE_BYPASS;
            end else if (r_neg) begin
                r_mode <= kpc_pkg::MODE_LOW;
            end else begin
                r_mode <= kpc_pkg::MODE_HIGH;
            end
        end
    end

    // Result register: holds a result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_tvalid        = r_out_valid;
    assign o_knob_position = r_pos;
    assign o_smoothed_mv   = r_mv_out;
    assign o_filter_mode   = r_mode;

    // Mode code agrees with the position held in the result register.
    a_mode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_mode == kpc_pkg::MODE_BYPASS) == (r_pos == '0)))
        else $error("bypass mode and zero position disagree");

    a_mode_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_mode == kpc_pkg::MODE_LOW)) |-> r_pos[PW-1])
        else $error("low-pass mode with a non-negative position");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (($signed(r_pos) <= 16'sd16384) && ($signed(r_pos) >= -16'sd16384)))
        else $error("position outside the unit range");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_st.busy)
        else $error("divider started while busy");

endmodule

// ===== src/knob_position_conditioner.sv =====
// Top level: configuration registers, burst front end, queue and back end.
// A burst total passes the queue, the sequencer states and one 26-step position division
// on its way to the result; the first burst skips the average update, a zero span the division.
// Throughput: one reading per cycle while the two-entry queue has room; the back end takes
// one burst at a time, and the queue holds the totals that wait for it.
// Reset (synchronous, active low) clears the burst sum, the average, its primed flag, the
// queue and the result valid flag, and loads the configuration registers with their defaults.
module knob_position_conditioner #(
    parameter int OVERSAMPLE_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Readings: [11:0] adc_mv, [15:12] zero.
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Results: [15:0] knob_position, [27:16] smoothed_mv, [31:28] zero.
    output logic [31:0] m_axis_tdata,
    // Results: [1:0] filter_mode.
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LIMIT = (OVERSAMPLE_COUNT < 1) ? 1 : OVERSAMPLE_COUNT;
    localparam int CNT_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
    localparam int SUM_W = kpc_pkg::ADC_W + CNT_W;

    kpc_pkg::t_cfg                  r_cfg;
    logic [kpc_pkg::IDX_W-1:0]      w_idx;
    logic                           w_wr;
    logic                           w_push;
    logic [SUM_W-1:0]               w_push_sum;
    logic                           w_pop;
    logic [SUM_W-1:0]               w_head;
    logic                           w_full;
    logic                           w_empty;
    logic [kpc_pkg::POS_W-1:0]      w_pos;
    logic [kpc_pkg::ADC_W-1:0]      w_mv;

    // Configuration register writes and reads.
    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_mv   <= kpc_pkg::RST_LEFT;
            r_cfg.center_mv <= kpc_pkg::RST_CENTER;
            r_cfg.right_mv  <= kpc_pkg::RST_RIGHT;
            r_cfg.ema_alpha <= kpc_pkg::RST_ALPHA;
            r_cfg.deadzone  <= kpc_pkg::RST_DEADZONE;
        end else if (w_wr) begin
            unique case (w_idx)
                kpc_pkg::IDX_LEFT:     r_cfg.left_mv   <= pwdata[kpc_pkg::ADC_W-1:0];
                kpc_pkg::IDX_CENTER:   r_cfg.center_mv <= pwdata[kpc_pkg::ADC_W-1:0];
                kpc_pkg::IDX_RIGHT:    r_cfg.right_mv  <= pwdata[kpc_pkg::ADC_W-1:0];
                kpc_pkg::IDX_ALPHA:    r_cfg.ema_alpha <= pwdata[kpc_pkg::ALPHA_W-1:0];
                kpc_pkg::IDX_DEADZONE: r_cfg.deadzone  <= pwdata[kpc_pkg::DZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            kpc_pkg::IDX_LEFT:     prdata = 32'(r_cfg.left_mv);
            kpc_pkg::IDX_CENTER:   prdata = 32'(r_cfg.center_mv);
            kpc_pkg::IDX_RIGHT:    prdata = 32'(r_cfg.right_mv);
            kpc_pkg::IDX_ALPHA:    prdata = 32'(r_cfg.ema_alpha);
            kpc_pkg::IDX_DEADZONE: prdata = 32'(r_cfg.deadzone);
            default:               prdata = '0;
        endcase
    end

    kpc_front #(
        .LIMIT (LIMIT),
        .SUM_W (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_adc_mv (s_axis_tdata[kpc_pkg::ADC_W-1:0]),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_sum    (w_push_sum)
    );

    kpc_fifo #(
        .WIDTH (SUM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_sum),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    kpc_back #(
        .LIMIT (LIMIT),
        .SUM_W (SUM_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_empty         (w_empty),
        .i_sum           (w_head),
        .o_pop           (w_pop),
        .o_tvalid        (m_axis_tvalid),
        .i_tready        (m_axis_tready),
        .o_knob_position (w_pos),
        .o_smoothed_mv   (w_mv),
        .o_filter_mode   (m_axis_tuser)
    );

    // Result packing, lowest field first.
    assign m_axis_tdata = {4'b0000, w_mv, w_pos};

endmodule

// ===== tb/kpc_checker.sv =====
// Checker for the knob position conditioner: predicts each result and compares it.
`timescale 1ns / 100ps

module kpc_checker
    import kpc_pkg::*;
#(
    parameter int OVERSAMPLE_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Reading channel: [11:0] adc_mv.
    input  logic [15:0] i_rd_tdata,
    input  logic        i_rd_tvalid,
    input  logic        i_rd_tready,
    // Result channel: [15:0] knob_position, [27:16] smoothed_mv.
    input  logic [31:0] i_res_tdata,
    // Result channel: [1:0] filter_mode.
    input  logic [1:0]  i_res_tuser,
    input  logic        i_res_tvalid,
    input  logic        i_res_tready,
    // Configuration port as seen by the block.
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned BURST_LEN = (OVERSAMPLE_COUNT < 1) ? 1 : OVERSAMPLE_COUNT;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [ADC_W-1:0]        mv;
        logic [MODE_W-1:0]       mode;
    } t_knob_result;

    // Shadow of the configuration and of the averaging state.
    t_cfg                cfg;
    int unsigned         burst_len_seen;
    int unsigned         burst_total;
    logic [SMOOTH_W-1:0] average_q16;
    logic                average_loaded;
    t_knob_result        expected_positions[$];
    int                  fail_count = 0;

    // Position on one half of the knob: num over the span, scaled to Q2.14 and clamped.
    function automatic logic signed [POS_W-1:0] half_position(input logic [ADC_W-1:0] num,
                                                              input int span,
                                                              input bit negate);
        int unsigned span_mag;
        int unsigned quotient;
        bit          neg;
        if (span == 0) begin
            return '0;
        end
        neg = negate;
        if (span < 0) begin
            span_mag = -span;
            neg      = !neg;
        end else begin
            span_mag = span;
        end
        quotient = (32'(num) << QPOS_W) / span_mag;
        if (quotient > 32'(POS_ONE)) begin
            quotient = 32'(POS_ONE);
        end
        return neg ? -POS_W'(quotient) : POS_W'(quotient);
    endfunction

    // Add one reading to the burst; a completed burst updates the average and
    // queues the position it leads to.
    task automatic fold_reading(input logic [ADC_W-1:0] adc);
        int unsigned             mean;
        logic [63:0]             acc;
        logic [ADC_W-1:0]        mv;
        logic signed [POS_W-1:0] pos;
        int                      pos_mag;
        t_knob_result            res;
        burst_total    += adc;
        burst_len_seen += 1;
        if (burst_len_seen < BURST_LEN) begin
            return;
        end
        mean           = burst_total / BURST_LEN;
        burst_total    = 0;
        burst_len_seen = 0;

        // The first burst after reset loads the average directly.
        if (!average_loaded) begin
            average_q16    = SMOOTH_W'(mean) << FRAC_W;
            average_loaded = 1'b1;
        end else begin
            acc = 64'(cfg.ema_alpha) * (64'(mean) << FRAC_W)
                + (64'd65536 - 64'(cfg.ema_alpha)) * 64'(average_q16);
            average_q16 = acc[FRAC_W +: SMOOTH_W];
        end
        mv = average_q16[FRAC_W +: ADC_W];

        // At or above the center the knob leans low-pass, below it high-pass, unless a span is reversed.
        if (mv >= cfg.center_mv) begin
            pos = half_position(mv - cfg.center_mv,
                                int'(cfg.left_mv) - int'(cfg.center_mv), 1'b1);
        end else begin
            pos = half_position(cfg.center_mv - mv,
                                int'(cfg.center_mv) - int'(cfg.right_mv), 1'b0);
        end
        pos_mag = (pos < 0) ? -int'(pos) : int'(pos);
        if (pos_mag < int'(cfg.deadzone)) begin
            pos = '0;
        end

        res.position = pos;
        res.mv       = mv;
        if (pos == 0) begin
            res.mode = MODE_BYPASS;
        end else if (pos < 0) begin
            res.mode = MODE_LOW;
        end else begin
            res.mode = MODE_HIGH;
        end
        expected_positions.push_back(res);
    endtask

    task automatic note_failure(input string msg);
        fail_count += 1;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Track configuration writes, readings and results on every edge.
    always @(posedge i_clk) begin
        t_knob_result want;
        t_knob_result got;
        if (!i_rst_n) begin
            cfg            = '{RST_LEFT, RST_CENTER, RST_RIGHT, RST_ALPHA, RST_DEADZONE};
            burst_len_seen = 0;
            burst_total    = 0;
            average_q16    = '0;
            average_loaded = 1'b0;
            expected_positions.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    IDX_LEFT:     cfg.left_mv   = i_pwdata[ADC_W-1:0];
                    IDX_CENTER:   cfg.center_mv = i_pwdata[ADC_W-1:0];
                    IDX_RIGHT:    cfg.right_mv  = i_pwdata[ADC_W-1:0];
                    IDX_ALPHA:    cfg.ema_alpha = i_pwdata[ALPHA_W-1:0];
                    IDX_DEADZONE: cfg.deadzone  = i_pwdata[DZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_rd_tvalid && i_rd_tready) begin
                fold_reading(i_rd_tdata[ADC_W-1:0]);
            end
            if (i_res_tvalid && i_res_tready) begin
                got.position = i_res_tdata[POS_W-1:0];
                got.mv       = i_res_tdata[16 +: ADC_W];
                got.mode     = i_res_tuser;
                if (expected_positions.size() == 0) begin
                    note_failure($sformatf("unexpected result pos=%0d mv=%0d mode=%0d",
                                           got.position, got.mv, got.mode));
                end else begin
                    want = expected_positions.pop_front();
                    if (got != want) begin
                        note_failure($sformatf(
                            "pos exp %0d got %0d, mv exp %0d got %0d, mode exp %0d got %0d",
                            want.position, got.position, want.mv, got.mv,
                            want.mode, got.mode));
                    end
                end
            end
        end
        o_pending    = expected_positions.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== tb/tb_knob_position_conditioner.sv =====
// Testbench top for the knob position conditioner: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb_knob_position_conditioner;
    import kpc_pkg::*;

    localparam int OVERSAMPLE_COUNT = 16;
    localparam int DRAIN_CYCLES     = 100;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int               fail_count;
    int               pending;
    int               run_left      = 0;
    int               readings_sent = 0;
    logic [ADC_W-1:0] cur_center    = RST_CENTER;

    // Clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    knob_position_conditioner #(
        .OVERSAMPLE_COUNT(OVERSAMPLE_COUNT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    kpc_checker #(
        .OVERSAMPLE_COUNT(OVERSAMPLE_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_tdata   (s_axis_tdata),
        .i_rd_tvalid  (s_axis_tvalid),
        .i_rd_tready  (s_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tuser  (m_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Result backpressure: the receiver switches between stall styles every so often.
    int unsigned ready_style = 0;
    int          ready_hold  = 0;
    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_hold  = $urandom_range(20, 120);
        end else begin
            ready_hold -= 1;
        end
        case (ready_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 1) != 0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Watchdog: too many cycles without any transaction ends the run.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles += 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One reading transaction; the sender pauses between runs of random length.
    task automatic send_reading(input logic [ADC_W-1:0] value);
        if (run_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                   : $urandom_range(1, 30);
        end
        run_left      -= 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, value};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        readings_sent += 1;
    endtask

    // Readings grouped per burst: full range, clustered, rail values or near the center.
    task automatic send_random_readings(input int count);
        int unsigned style;
        int          base;
        int          value;
        style = 0;
        base  = 0;
        for (int i = 0; i < count; i++) begin
            if (readings_sent % OVERSAMPLE_COUNT == 0) begin
                style = $urandom_range(0, 3);
                base  = (style == 3) ? int'(cur_center) : int'($urandom_range(0, 4095));
            end
            case (style)
                0: value = $urandom_range(0, 4095);
                1: value = base + int'($urandom_range(0, 127)) - 64;
                2: value = $urandom_range(0, 1) ? 4095 : 0;
                default: value = base + int'($urandom_range(0, 400)) - 200;
            endcase
            if (value < 0) value = 0;
            if (value > 4095) value = 4095;
            send_reading(ADC_W'(value));
        end
    endtask

    // Wait until every expected result is out and the back end has settled.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One write transaction: setup cycle, then access cycle until pready.
    task automatic cfg_write(input logic [IDX_W-1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (index == IDX_CENTER) cur_center = value[ADC_W-1:0];
    endtask

    // Reprogram every register while idle, optionally poking unmapped addresses too.
    task automatic apply_cfg(input logic [31:0] left, input logic [31:0] center,
                             input logic [31:0] right, input logic [31:0] alpha,
                             input logic [31:0] dz, input bit poke_unmapped);
        wait_idle();
        cfg_write(IDX_LEFT, left);
        cfg_write(IDX_CENTER, center);
        cfg_write(IDX_RIGHT, right);
        cfg_write(IDX_ALPHA, alpha);
        cfg_write(IDX_DEADZONE, dz);
        if (poke_unmapped) begin
            for (int k = int'(IDX_DEADZONE) + 1; k < 2 ** IDX_W; k++) begin
                cfg_write(IDX_W'(k), $urandom());
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the priming burst at the low rail, then one at the high rail.
        repeat (OVERSAMPLE_COUNT) send_reading('0);
        repeat (OVERSAMPLE_COUNT) send_reading('1);
        send_random_readings(40);

        // Zero span on the low-pass half, then on the high-pass half.
        apply_cfg(2000, 2000, 100, 13107, 492, 1'b0);
        send_random_readings($urandom_range(35, 60));
        apply_cfg(3000, 1500, 1500, 20000, 0, 1'b0);
        send_random_readings($urandom_range(35, 60));
        // Both spans reversed.
        apply_cfg(1000, 2000, 3000, 30000, 300, 1'b0);
        send_random_readings($urandom_range(35, 60));
        // Alpha zero freezes the average.
        apply_cfg(3145, 2100, 142, 0, 492, 1'b1);
        send_random_readings($urandom_range(35, 60));
        // Register extremes in both directions.
        apply_cfg(4095, 0, 0, 65535, 0, 1'b0);
        send_random_readings($urandom_range(35, 60));
        apply_cfg(0, 4095, 4095, 65535, 100, 1'b0);
        send_random_readings($urandom_range(35, 60));
        // Oversized write values get masked; deadzone becomes larger than full scale.
        apply_cfg(32'hFFFF_FBB8, 32'hA5A5_A800, 32'h1234_51F4, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 1'b0);
        send_random_readings($urandom_range(35, 60));
        // Deadzone exactly at full scale keeps only clamped positions.
        apply_cfg(3145, 2100, 142, 40000, 16384, 1'b0);
        send_random_readings($urandom_range(35, 60));

        // Random settings.
        for (int p = 0; p < 5; p++) begin
            apply_cfg($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom_range(0, 2000), p == 2);
            send_random_readings($urandom_range(35, 60));
        end
        apply_cfg(RST_LEFT, RST_CENTER, RST_RIGHT, RST_ALPHA, RST_DEADZONE, 1'b0);
        send_random_readings($urandom_range(35, 60));

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/kpc_pkg.sv
src/kpc_front.sv
src/kpc_fifo.sv
src/kpc_div.sv
src/kpc_back.sv
src/knob_position_conditioner.sv
tb/kpc_checker.sv
tb/tb_knob_position_conditioner.sv
